// File: hw/rtl/bpc_pkg.sv
// shared widths, constants and types for the barometer compensation core
package bpc_pkg;

	localparam int RAW_W    = 20;
	localparam int TEMP_W   = 24;
	localparam int PRESS_W  = 32;
	localparam int CFG_W    = 48;
	localparam int CFG_IDX_W = 2;
	localparam int N_CFG    = 4;

	// signed dividend and divisor magnitudes of the pressure division
	localparam int NUM_W    = 64;
	localparam int DEN_W    = 31;
	localparam int REM_W    = DEN_W;

	// offset fine temperature and full scale of the raw pressure code
	localparam int V_W         = 23;
	localparam int TEMP_OFFSET = 128000;
	localparam int P_FULL      = 1048576;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMP    = 2'd0,
		CFG_PRESS_A = 2'd1,
		CFG_PRESS_B = 2'd2,
		CFG_PRESS_C = 2'd3
	} cfg_idx_t;

	// sideband that rides along with a division
	typedef struct packed {
		logic [TEMP_W-1:0] temp;
		logic              neg;
		logic              zero;
	} div_side_t;

endpackage

// File: hw/rtl/baro_temp_pressure_compensate_core.sv
// Barometer compensation core. Each beat on the input carries one raw temperature and one raw
// pressure code; each output beat carries temperature in hundredths of a degree, pressure in
// pascal as unsigned Q24.8 and a flag that is low when the divisor is zero or the pressure is
// not positive. One beat is taken every clock cycle while in_ready is high; the divider resolves one
// quotient bit per stage. A stalled output holds in the output register while earlier stages keep
// filling empty slots, so empty slots are squeezed out one stage per cycle. Coefficients must be
// written through the cfg port only while no beat is in flight; the core does not enforce this.
module baro_temp_pressure_compensate_core import bpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [RAW_W-1:0]     raw_temperature,
	input  logic [RAW_W-1:0]     raw_pressure,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [TEMP_W-1:0] temp_centi_deg,
	output logic [PRESS_W-1:0]   pressure_q24_8,
	output logic                 valid_res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int STG = 18;

	// coefficient registers
	logic [CFG_W-1:0] cfg_q [N_CFG];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_CFG; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TEMP:    cfg_q[CFG_TEMP]    <= cfg_data;
				CFG_PRESS_A: cfg_q[CFG_PRESS_A] <= cfg_data;
				CFG_PRESS_B: cfg_q[CFG_PRESS_B] <= cfg_data;
				CFG_PRESS_C: cfg_q[CFG_PRESS_C] <= cfg_data;
			endcase
		end
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = cfg_q[CFG_TEMP][15:0];
	assign t2 = cfg_q[CFG_TEMP][31:16];
	assign t3 = cfg_q[CFG_TEMP][47:32];
	assign p1 = cfg_q[CFG_PRESS_A][15:0];
	assign p2 = cfg_q[CFG_PRESS_A][31:16];
	assign p3 = cfg_q[CFG_PRESS_A][47:32];
	assign p4 = cfg_q[CFG_PRESS_B][15:0];
	assign p5 = cfg_q[CFG_PRESS_B][31:16];
	assign p6 = cfg_q[CFG_PRESS_B][47:32];
	assign p7 = cfg_q[CFG_PRESS_C][15:0];
	assign p8 = cfg_q[CFG_PRESS_C][31:16];
	assign p9 = cfg_q[CFG_PRESS_C][47:32];

	// stage flow control: a stage loads when the line advances or when it is empty
	logic [STG:1] vld_s, en, prv, tk;
	logic         adv;
	logic         div_in_take, div_out_vld;
	logic [NUM_W-1:0] div_quo;
	div_side_t    div_side_out;

	assign adv      = ~vld_s[STG] | out_ready;
	assign en       = {STG{adv}} | ~vld_s;
	assign in_ready = en[1];
	assign prv      = {vld_s[17:11], div_out_vld, vld_s[9:1], in_valid};
	assign tk       = {out_ready, en[18:12], div_in_take, en[10:2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= STG; k++) begin
				if (en[k]) begin
					vld_s[k] <= prv[k];
				end else if (tk[k]) begin
					vld_s[k] <= 1'b0;
				end
			end
		end
	end

	// stage 1: offsets and first temperature products
	logic signed [17:0] a_c;
	logic signed [16:0] d_c;
	logic signed [33:0] at_c, dd_c;

	assign a_c  = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
	assign d_c  = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
	assign at_c = a_c * t2;
	assign dd_c = d_c * d_c;

	logic [31:0]      at_s1, dd_s1;
	logic [RAW_W-1:0] rp_s1;

	// stage 2
	logic signed [20:0] va_c;
	logic signed [19:0] e_c;
	logic signed [35:0] et_c;

	assign va_c = at_s1[31:11];
	assign e_c  = dd_s1[31:12];
	assign et_c = e_c * t3;

	logic signed [20:0] va_s2;
	logic [31:0]        et_s2;
	logic [RAW_W-1:0]   rp_s2;

	// stage 3: fine temperature, rounded output temperature
	logic signed [17:0] vb_c;
	logic [21:0]        fine_c;
	logic [25:0]        f26_c, f5_c;
	logic [V_W-1:0]     v_c;
	logic [20:0]        pr_c;

	assign vb_c   = et_s2[31:14];
	assign fine_c = {va_s2[20], va_s2} + {{4{vb_c[17]}}, vb_c};
	assign f26_c  = {{4{fine_c[21]}}, fine_c};
	assign f5_c   = {f26_c[23:0], 2'b00} + f26_c + 26'd128;
	assign v_c    = {fine_c[21], fine_c} - V_W'(TEMP_OFFSET);
	assign pr_c   = 21'(P_FULL) - {1'b0, rp_s2};

	// the shifted value always fits the output field, so no clamp is needed
	logic [TEMP_W-1:0]     temp_s3;
	logic signed [V_W-1:0] v_s3;
	logic [20:0]           pr_s3;

	// stage 4
	logic signed [45:0] vv_c;
	logic signed [38:0] vp5_c, vp2_c;

	assign vv_c  = v_s3 * v_s3;
	assign vp5_c = v_s3 * p5;
	assign vp2_c = v_s3 * p2;

	logic signed [45:0] vv_s4;
	logic signed [38:0] vp5_s4, vp2_s4;
	logic [TEMP_W-1:0]  temp_s4;
	logic [20:0]        pr_s4;

	// stage 5
	logic signed [61:0] vvp6_c, vvp3_c;

	assign vvp6_c = vv_s4 * p6;
	assign vvp3_c = vv_s4 * p3;

	logic signed [61:0] vvp6_s5, vvp3_s5;
	logic [38:0]        vp5_s5, vp2_s5;
	logic [TEMP_W-1:0]  temp_s5;
	logic [20:0]        pr_s5;

	// stage 6: polynomial sums
	logic [63:0] x2_c, b_c;

	assign x2_c = {{2{vvp6_s5[61]}}, vvp6_s5} + {{8{vp5_s5[38]}}, vp5_s5, 17'b0}
		+ {{13{p4[15]}}, p4, 35'b0};
	assign b_c  = {{10{vvp3_s5[61]}}, vvp3_s5[61:8]} + {{13{vp2_s5[38]}}, vp2_s5, 12'b0}
		+ (64'd1 << 47);

	logic [63:0]        x2_s6;
	logic signed [55:0] b_s6;
	logic [TEMP_W-1:0]  temp_s6;
	logic [20:0]        pr_s6;

	// stage 7: divisor and unscaled dividend
	logic signed [72:0] bp_c;
	logic [63:0]        t_c;

	assign bp_c = b_s6 * $signed({1'b0, p1});
	assign t_c  = {12'b0, pr_s6, 31'b0} - x2_s6;

	logic [DEN_W-1:0]  den_s7;
	logic [63:0]       t_s7;
	logic [TEMP_W-1:0] temp_s7;

	// stage 8: times 3125 as two partial sums
	logic [63:0] ta_c, tb_c;

	assign ta_c = (t_s7 << 11) + (t_s7 << 10) + (t_s7 << 5);
	assign tb_c = (t_s7 << 4) + (t_s7 << 2) + t_s7;

	logic [63:0]       ta_s8, tb_s8;
	logic [DEN_W-1:0]  den_s8;
	logic [TEMP_W-1:0] temp_s8;

	// stage 9
	logic [NUM_W-1:0]  num_s9;
	logic [DEN_W-1:0]  den_s9;
	logic [TEMP_W-1:0] temp_s9;

	// stage 10: split into sign and magnitude
	logic [NUM_W-1:0] nmag_c;
	logic [DEN_W-1:0] dmag_c;
	div_side_t        side_c;

	assign nmag_c      = num_s9[NUM_W-1] ? (~num_s9 + 1'b1) : num_s9;
	assign dmag_c      = den_s9[DEN_W-1] ? (~den_s9 + 1'b1) : den_s9;
	assign side_c.temp = temp_s9;
	assign side_c.neg  = num_s9[NUM_W-1] ^ den_s9[DEN_W-1];
	assign side_c.zero = (den_s9 == '0);

	logic [NUM_W-1:0] nmag_s10;
	logic [DEN_W-1:0] dmag_s10;
	div_side_t        side_s10;

	bpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vld_s[10]),
		.in_take  (div_in_take),
		.num_mag  (nmag_s10),
		.den_mag  (dmag_s10),
		.in_side  (side_s10),
		.out_vld  (div_out_vld),
		.out_take (en[11]),
		.quo      (div_quo),
		.out_side (div_side_out)
	);

	// stage 11: restore the quotient sign, wrapping like the 64-bit form
	logic [63:0]       q_s11;
	logic [TEMP_W-1:0] temp_s11;
	logic              zero_s11;

	// stage 12: partial products of the two correction terms
	logic [63:0]        s_c;
	logic signed [48:0] mlo_c, nlo_c;
	logic [31:0]        mhi_c, nhi_c;

	assign s_c   = {{13{q_s11[63]}}, q_s11[63:13]};
	assign mlo_c = $signed({1'b0, s_c[31:0]}) * p9;
	assign mhi_c = s_c[63:32] * {{16{p9[15]}}, p9};
	assign nlo_c = $signed({1'b0, q_s11[31:0]}) * p8;
	assign nhi_c = q_s11[63:32] * {{16{p8[15]}}, p8};

	logic [48:0]       mlo_s12, nlo_s12;
	logic [31:0]       mhi_s12, nhi_s12;
	logic [63:0]       s_s12, q_s12;
	logic [TEMP_W-1:0] temp_s12;
	logic              zero_s12;

	// stage 13
	logic [63:0] m_c, n_c;

	assign m_c = {{15{mlo_s12[48]}}, mlo_s12} + {mhi_s12, 32'b0};
	assign n_c = {{15{nlo_s12[48]}}, nlo_s12} + {nhi_s12, 32'b0};

	logic [63:0]       m_s13, s_s13, q_s13, q2_s13;
	logic [TEMP_W-1:0] temp_s13;
	logic              zero_s13;

	// stage 14: low 64 bits of m times s
	logic [63:0] u0_c;
	logic [31:0] u1_c, u2_c;

	assign u0_c = m_s13[31:0] * s_s13[31:0];
	assign u1_c = m_s13[31:0] * s_s13[63:32];
	assign u2_c = m_s13[63:32] * s_s13[31:0];

	logic [63:0]       u0_s14, q_s14, q2_s14;
	logic [31:0]       u1_s14, u2_s14;
	logic [TEMP_W-1:0] temp_s14;
	logic              zero_s14;

	// stage 15
	logic [63:0] u_c;

	assign u_c = u0_s14 + {u1_s14 + u2_s14, 32'b0};

	logic [63:0]       q1_s15, qq_s15;
	logic [TEMP_W-1:0] temp_s15;
	logic              zero_s15;

	// stage 16
	logic [63:0]       tot_s16;
	logic [TEMP_W-1:0] temp_s16;
	logic              zero_s16;

	// stage 17
	logic [63:0]       p_s17;
	logic [TEMP_W-1:0] temp_s17;
	logic              zero_s17;

	// stage 18: output register, positive check and saturation
	logic              ok_c;

	assign ok_c = ~zero_s17 & ~p_s17[63] & (p_s17 != '0);

	logic [TEMP_W-1:0]  temp_s18;
	logic [PRESS_W-1:0] press_s18;
	logic               vres_s18;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			at_s1 <= at_c[31:0];
			dd_s1 <= dd_c[31:0];
			rp_s1 <= raw_pressure;
		end
		if (en[2]) begin
			va_s2 <= va_c;
			et_s2 <= et_c[31:0];
			rp_s2 <= rp_s1;
		end
		if (en[3]) begin
			temp_s3 <= {{6{f5_c[25]}}, f5_c[25:8]};
			v_s3    <= v_c;
			pr_s3   <= pr_c;
		end
		if (en[4]) begin
			vv_s4   <= vv_c;
			vp5_s4  <= vp5_c;
			vp2_s4  <= vp2_c;
			temp_s4 <= temp_s3;
			pr_s4   <= pr_s3;
		end
		if (en[5]) begin
			vvp6_s5 <= vvp6_c;
			vvp3_s5 <= vvp3_c;
			vp5_s5  <= vp5_s4;
			vp2_s5  <= vp2_s4;
			temp_s5 <= temp_s4;
			pr_s5   <= pr_s4;
		end
		if (en[6]) begin
			x2_s6   <= x2_c;
			b_s6    <= b_c[55:0];
			temp_s6 <= temp_s5;
			pr_s6   <= pr_s5;
		end
		if (en[7]) begin
			den_s7  <= bp_c[63:33];
			t_s7    <= t_c;
			temp_s7 <= temp_s6;
		end
		if (en[8]) begin
			ta_s8   <= ta_c;
			tb_s8   <= tb_c;
			den_s8  <= den_s7;
			temp_s8 <= temp_s7;
		end
		if (en[9]) begin
			num_s9  <= ta_s8 + tb_s8;
			den_s9  <= den_s8;
			temp_s9 <= temp_s8;
		end
		if (en[10]) begin
			nmag_s10 <= nmag_c;
			dmag_s10 <= dmag_c;
			side_s10 <= side_c;
		end
		if (en[11]) begin
			q_s11    <= div_side_out.neg ? (~div_quo + 1'b1) : div_quo;
			temp_s11 <= div_side_out.temp;
			zero_s11 <= div_side_out.zero;
		end
		if (en[12]) begin
			mlo_s12  <= mlo_c;
			mhi_s12  <= mhi_c;
			nlo_s12  <= nlo_c;
			nhi_s12  <= nhi_c;
			s_s12    <= s_c;
			q_s12    <= q_s11;
			temp_s12 <= temp_s11;
			zero_s12 <= zero_s11;
		end
		if (en[13]) begin
			m_s13    <= m_c;
			s_s13    <= s_s12;
			q_s13    <= q_s12;
			q2_s13   <= {{19{n_c[63]}}, n_c[63:19]};
			temp_s13 <= temp_s12;
			zero_s13 <= zero_s12;
		end
		if (en[14]) begin
			u0_s14   <= u0_c;
			u1_s14   <= u1_c;
			u2_s14   <= u2_c;
			q_s14    <= q_s13;
			q2_s14   <= q2_s13;
			temp_s14 <= temp_s13;
			zero_s14 <= zero_s13;
		end
		if (en[15]) begin
			q1_s15   <= {{25{u_c[63]}}, u_c[63:25]};
			qq_s15   <= q_s14 + q2_s14;
			temp_s15 <= temp_s14;
			zero_s15 <= zero_s14;
		end
		if (en[16]) begin
			tot_s16  <= q1_s15 + qq_s15;
			temp_s16 <= temp_s15;
			zero_s16 <= zero_s15;
		end
		if (en[17]) begin
			p_s17    <= {{8{tot_s16[63]}}, tot_s16[63:8]} + {{44{p7[15]}}, p7, 4'b0};
			temp_s17 <= temp_s16;
			zero_s17 <= zero_s16;
		end
		if (en[18]) begin
			temp_s18 <= temp_s17;
			vres_s18 <= ok_c;
			if (!ok_c) begin
				press_s18 <= '0;
			end else if (p_s17[63:32] != '0) begin
				press_s18 <= '1;
			end else begin
				press_s18 <= p_s17[31:0];
			end
		end
	end

	assign out_valid      = vld_s[STG];
	assign temp_centi_deg = temp_s18;
	assign pressure_q24_8 = press_s18;
	assign valid_res      = vres_s18;

	ap_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> pressure_q24_8 != '0)
		else $error("flagged result carries zero pressure");

	ap_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> pressure_q24_8 == '0)
		else $error("unflagged result carries nonzero pressure");

	ap_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		div_out_vld && !en[11] |=> div_out_vld)
		else $error("divider dropped a beat while stage 11 was blocked");

endmodule

// File: hw/rtl/bpc_div.sv
// pipelined signed-magnitude divider, one quotient bit per stage
module bpc_div import bpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_vld,
	output logic             in_take,
	input  logic [NUM_W-1:0] num_mag,
	input  logic [DEN_W-1:0] den_mag,
	input  div_side_t        in_side,
	output logic             out_vld,
	input  logic             out_take,
	output logic [NUM_W-1:0] quo,
	output div_side_t        out_side
);

	localparam int NST = NUM_W;

	logic             vld_s  [NST];
	logic             en     [NST];
	logic [REM_W-1:0] rem_s  [NST];
	logic [NUM_W-1:0] qn_s   [NST];
	logic [DEN_W-1:0] den_s  [NST];
	div_side_t        side_s [NST];

	assign in_take  = en[0];
	assign out_vld  = vld_s[NST-1];
	assign quo      = qn_s[NST-1];
	assign out_side = side_s[NST-1];

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic [REM_W-1:0] rem_in;
		logic [NUM_W-1:0] qn_in;
		logic [DEN_W-1:0] den_in;
		div_side_t        side_in;
		logic             vld_in;
		logic             take_out;
		logic [REM_W:0]   trial;
		logic [REM_W+1:0] diff;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign qn_in   = num_mag;
			assign den_in  = den_mag;
			assign side_in = in_side;
			assign vld_in  = in_vld;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign qn_in   = qn_s[k-1];
			assign den_in  = den_s[k-1];
			assign side_in = side_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		if (k == NST-1) begin : g_last
			assign take_out = out_take;
		end else begin : g_mid
			assign take_out = en[k+1];
		end

		assign en[k] = adv | ~vld_s[k];

		// bring down the next dividend bit and try the subtract
		assign trial = {rem_in, qn_in[NUM_W-1]};
		assign diff  = {1'b0, trial} - {2'b00, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= vld_in;
			end else if (take_out) begin
				vld_s[k] <= 1'b0;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				if (!diff[REM_W+1]) begin
					rem_s[k] <= diff[REM_W-1:0];
				end else begin
					rem_s[k] <= trial[REM_W-1:0];
				end
				qn_s[k]   <= {qn_in[NUM_W-2:0], ~diff[REM_W+1]};
				den_s[k]  <= den_in;
				side_s[k] <= side_in;
			end
		end
	end

endmodule
